// ----- hw/rtl/cc20_pkg.sv -----
// Shared types, constants and round functions for the ChaCha20 stream XOR block.
// No dependencies; imported by every module of the block.
`default_nettype none

package cc20_pkg;

    typedef logic [15:0][31:0] t_state;
    typedef logic [3:0][31:0]  t_quad;
    typedef logic [7:0][63:0]  t_block;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_KEY_LOW      = 3'd0;
    localparam t_cfg_idx REG_KEY_MID_LOW  = 3'd1;
    localparam t_cfg_idx REG_KEY_MID_HIGH = 3'd2;
    localparam t_cfg_idx REG_KEY_HIGH     = 3'd3;
    localparam t_cfg_idx REG_SALT_WORD    = 3'd4;
    localparam t_cfg_idx REG_IV_WORD      = 3'd5;

    localparam t_quad SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};

    typedef struct packed {
        logic [255:0] key;
        logic [31:0]  salt;
        logic [63:0]  iv;
    } t_cfg;

    typedef struct packed {
        t_block      data;
        logic [63:0] byte_en;
        logic [6:0]  byte_count;
        logic        last;
        logic [31:0] ctr;
    } t_entry;

    function automatic t_quad cc20_qr(t_quad q);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = q[0];
        b = q[1];
        c = q[2];
        d = q[3];
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        return {d, c, b, a};
    endfunction

    // Even rounds work on columns, odd rounds on diagonals; the four
    // quarter rounds of one round touch disjoint words.
    function automatic t_state cc20_round(t_state s, logic diag);
        t_state     r;
        t_quad      q;
        logic [1:0] k;
        logic [3:0] ia;
        logic [3:0] ib;
        logic [3:0] ic;
        logic [3:0] id;
        r = s;
        for (int i = 0; i < 4; i++) begin
            k  = 2'(i);
            ia = {2'b00, k};
            ib = {2'b01, 2'(k + {1'b0, diag})};
            ic = {2'b10, 2'(k + {diag, 1'b0})};
            id = {2'b11, 2'(k + {diag, diag})};
            q  = cc20_qr({s[id], s[ic], s[ib], s[ia]});
            r[ia] = q[0];
            r[ib] = q[1];
            r[ic] = q[2];
            r[id] = q[3];
        end
        return r;
    endfunction

    function automatic t_state cc20_init(t_cfg cfg, logic [31:0] ctr);
        t_state r;
        r[0] = SIGMA[0];
        r[1] = SIGMA[1];
        r[2] = SIGMA[2];
        r[3] = SIGMA[3];
        for (int i = 0; i < 8; i++) begin
            r[4'(4 + i)] = cfg.key[32*i +: 32];
        end
        r[12] = ctr;
        r[13] = cfg.salt;
        r[14] = cfg.iv[31:0];
        r[15] = cfg.iv[63:32];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/chacha20_stream_xor.sv -----
// ChaCha20 stream XOR, IETF layout: 32-bit block counter, 96-bit nonce of salt and iv.
// Holds the configuration registers. Depends on cc20_pkg, cc20_front, cc20_queue, cc20_core.
//
// Usage: configuration words (key, salt, iv) are written on the cfg channel while the
// block is idle; index 0 to 3 are the key, 4 the salt, 5 the iv, other indexes are
// ignored. Each input word is one 64-byte block as eight little-endian 64-bit lanes
// with a byte count and a last flag. Each output word carries the data XORed with the
// keystream, bytes at or beyond the count forced to zero, and the copied count and flag.
// The block counter starts at 1, increments per block and returns to 1 after a last block.
// The round engine computes one round per cycle until its last round, where it waits for
// a free output register; it takes the next block from the queue in the same cycle as
// it finishes the current one.
// A two-entry queue in front of the engine accepts new blocks while it works, and the
// output register holds a finished word while the next block runs. When the receiver
// stalls the output word holds, the engine then waits at its last round, and input
// ready drops once the queue is full. Reset clears the queue, the engine, the output
// valid, the configuration to zero and the counter to 1.
`default_nettype none

module chacha20_stream_xor #(
    parameter int DOUBLE_ROUND_COUNT = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_data_0,
    input  wire logic [63:0] i_data_1,
    input  wire logic [63:0] i_data_2,
    input  wire logic [63:0] i_data_3,
    input  wire logic [63:0] i_data_4,
    input  wire logic [63:0] i_data_5,
    input  wire logic [63:0] i_data_6,
    input  wire logic [63:0] i_data_7,
    input  wire logic [6:0]  i_byte_count,
    input  wire logic        i_last_block,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_out_0,
    output logic [63:0]      o_out_1,
    output logic [63:0]      o_out_2,
    output logic [63:0]      o_out_3,
    output logic [63:0]      o_out_4,
    output logic [63:0]      o_out_5,
    output logic [63:0]      o_out_6,
    output logic [63:0]      o_out_7,
    output logic [6:0]       o_out_byte_count,
    output logic             o_out_last
);
    import cc20_pkg::*;

    logic [63:0] r_key_low;
    logic [63:0] r_key_mid_low;
    logic [63:0] r_key_mid_high;
    logic [63:0] r_key_high;
    logic [31:0] r_salt;
    logic [63:0] r_iv;

    t_cfg   cfg;
    t_block in_data;
    t_block out_data;
    t_entry push_entry;
    t_entry pop_entry;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_nonempty;
    logic   cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low      <= '0;
            r_key_mid_low  <= '0;
            r_key_mid_high <= '0;
            r_key_high     <= '0;
            r_salt         <= '0;
            r_iv           <= '0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY_LOW:      r_key_low      <= i_cfg_data;
                REG_KEY_MID_LOW:  r_key_mid_low  <= i_cfg_data;
                REG_KEY_MID_HIGH: r_key_mid_high <= i_cfg_data;
                REG_KEY_HIGH:     r_key_high     <= i_cfg_data;
                REG_SALT_WORD:    r_salt         <= i_cfg_data[31:0];
                REG_IV_WORD:      r_iv           <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.key  = {r_key_high, r_key_mid_high, r_key_mid_low, r_key_low};
    assign cfg.salt = r_salt;
    assign cfg.iv   = r_iv;

    assign in_data = {i_data_7, i_data_6, i_data_5, i_data_4,
                      i_data_3, i_data_2, i_data_1, i_data_0};

    cc20_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data       (in_data),
        .i_byte_count (i_byte_count),
        .i_last_block (i_last_block),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    cc20_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (push_entry),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_entry    (pop_entry)
    );

    cc20_core #(
        .DOUBLE_ROUND_COUNT (DOUBLE_ROUND_COUNT)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_q_nonempty     (q_nonempty),
        .i_q_entry        (pop_entry),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out            (out_data),
        .o_out_byte_count (o_out_byte_count),
        .o_out_last       (o_out_last)
    );

    assign o_out_0 = out_data[0];
    assign o_out_1 = out_data[1];
    assign o_out_2 = out_data[2];
    assign o_out_3 = out_data[3];
    assign o_out_4 = out_data[4];
    assign o_out_5 = out_data[5];
    assign o_out_6 = out_data[6];
    assign o_out_7 = out_data[7];

endmodule

`default_nettype wire

// ----- hw/rtl/cc20_front.sv -----
// Input side: takes words, builds the byte enables and assigns the block counter.
// Depends on cc20_pkg.
`default_nettype none

module cc20_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire cc20_pkg::t_block i_data,
    input  wire logic [6:0]     i_byte_count,
    input  wire logic           i_last_block,
    input  wire logic           i_queue_full,
    output logic                o_push,
    output cc20_pkg::t_entry    o_entry
);
    import cc20_pkg::*;

    logic [31:0] r_ctr;
    logic [31:0] n_ctr;
    logic [63:0] byte_en;

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // A count above 64 enables every byte, a count of zero none.
    always_comb begin
        for (int j = 0; j < 64; j++) begin
            byte_en[j] = (7'(j) < i_byte_count);
        end
    end

    always_comb begin
        n_ctr = r_ctr;
        if (o_push) begin
            n_ctr = i_last_block ? 32'd1 : r_ctr + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= 32'd1;
        end else begin
            r_ctr <= n_ctr;
        end
    end

    assign o_entry.data       = i_data;
    assign o_entry.byte_en    = byte_en;
    assign o_entry.byte_count = i_byte_count;
    assign o_entry.last       = i_last_block;
    assign o_entry.ctr        = r_ctr;

endmodule

`default_nettype wire

// ----- hw/rtl/cc20_queue.sv -----
// Two-entry queue of classified blocks between the front and the round engine.
// Depends on cc20_pkg.
`default_nettype none

module cc20_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire cc20_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_nonempty,
    output cc20_pkg::t_entry      o_entry
);
    import cc20_pkg::*;

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_entry    = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cc20_core.sv -----
// Round engine: one ChaCha round per cycle, then, once the output register is free, the
// feed-forward add, XOR and byte masking into it. Depends on cc20_pkg.
`default_nettype none

module cc20_core #(
    parameter int DOUBLE_ROUND_COUNT = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cc20_pkg::t_cfg   i_cfg,
    input  wire logic             i_q_nonempty,
    input  wire cc20_pkg::t_entry i_q_entry,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output cc20_pkg::t_block      o_out,
    output logic [6:0]            o_out_byte_count,
    output logic                  o_out_last
);
    import cc20_pkg::*;

    localparam int ROUNDS = 2 * DOUBLE_ROUND_COUNT;
    localparam int RND_W  = $clog2(ROUNDS + 1);

    t_state         r_w;
    logic [RND_W-1:0] r_rnd;
    logic           r_busy;
    t_block         r_data;
    logic [63:0]    r_en;
    logic [6:0]     r_cnt;
    logic           r_last;
    logic [31:0]    r_ctr;
    logic           r_ov;
    t_block         r_out;
    logic [6:0]     r_out_cnt;
    logic           r_out_last;

    t_state         load_init;
    t_state         fin_init;
    t_block         result;
    logic           done;
    logic           out_free;
    logic           finish;
    logic           take;

    assign load_init = cc20_init(i_cfg, i_q_entry.ctr);
    assign fin_init  = cc20_init(i_cfg, r_ctr);

    assign done     = r_busy && (r_rnd == RND_W'(ROUNDS));
    assign out_free = !r_ov || i_out_ready;
    assign finish   = done && out_free;
    assign take     = i_q_nonempty && (!r_busy || finish);
    assign o_pop    = take;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            result[i] = {r_w[2*i+1] + fin_init[2*i+1], r_w[2*i] + fin_init[2*i]}
                        ^ r_data[i];
            for (int b = 0; b < 8; b++) begin
                if (!r_en[8*i + b]) begin
                    result[i][8*b +: 8] = 8'h00;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_w    <= cc20_round(load_init, 1'b0);
            r_data <= i_q_entry.data;
            r_en   <= i_q_entry.byte_en;
            r_cnt  <= i_q_entry.byte_count;
            r_last <= i_q_entry.last;
            r_ctr  <= i_q_entry.ctr;
        end else if (r_busy && !done) begin
            r_w <= cc20_round(r_w, r_rnd[0]);
        end
        if (finish) begin
            r_out      <= result;
            r_out_cnt  <= r_cnt;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
                r_rnd  <= RND_W'(1);
            end else if (finish) begin
                r_busy <= 1'b0;
            end else if (r_busy && !done) begin
                r_rnd <= r_rnd + RND_W'(1);
            end
            if (finish) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_ov;
    assign o_out            = r_out;
    assign o_out_byte_count = r_out_cnt;
    assign o_out_last       = r_out_last;

endmodule

`default_nettype wire

// ----- hw/rtl/cc20_check.sv -----
// Port-level checks for chacha20_stream_xor and the bind that attaches them.
// Depends on chacha20_stream_xor only through its ports.
`default_nettype none

module cc20_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_out_0,
    input wire logic [63:0] o_out_7,
    input wire logic [6:0]  o_out_byte_count,
    input wire logic        o_out_last
);

    // A stalled output word keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_0)
            && $stable(o_out_7) && $stable(o_out_byte_count) && $stable(o_out_last))
        else $error("output word changed while stalled");

    // The queue is empty after reset, so input is taken at once.
    a_ready_after_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> o_in_ready)
        else $error("input not ready after reset");

    // Bytes past the count come out as zero; checked on lane 7 for counts of 56 or less.
    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_byte_count <= 7'd56 |-> o_out_7 == 64'd0)
        else $error("bytes beyond the count are not zero");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_byte_count == 7'd0 |-> o_out_0 == 64'd0)
        else $error("zero-count word carries data");

endmodule

bind chacha20_stream_xor cc20_check u_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_0          (o_out_0),
    .o_out_7          (o_out_7),
    .o_out_byte_count (o_out_byte_count),
    .o_out_last       (o_out_last)
);

`default_nettype wire

// ----- verif/chacha20_checker.sv -----
// Scoreboard for chacha20_stream_xor: mirrors the key, salt, iv and block counter,
// predicts each cipher word from the accepted input and compares the output word.
// Depends on cc20_pkg for the block and register index types.
module cc20_xor_checker #(
    parameter int DOUBLE_ROUND_COUNT = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  cc20_pkg::t_cfg_idx   i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  cc20_pkg::t_block     i_in_data,
    input  logic [6:0]           i_in_count,
    input  logic                 i_in_last,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  cc20_pkg::t_block     i_out_data,
    input  logic [6:0]           i_out_count,
    input  logic                 i_out_last,
    output int                   o_mismatch_count,
    output int                   o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import cc20_pkg::*;

    typedef logic [15:0][31:0] t_cc_words;

    typedef struct packed {
        t_block     lanes;
        logic [6:0] count;
        logic       last;
    } t_cipher_word;

    localparam logic [31:0] EXPAND_0 = 32'h61707865;
    localparam logic [31:0] EXPAND_1 = 32'h3320646e;
    localparam logic [31:0] EXPAND_2 = 32'h79622d32;
    localparam logic [31:0] EXPAND_3 = 32'h6b206574;
    localparam logic [6:0]  FULL_BLOCK = 7'd64;

    logic [255:0]   key;
    logic [31:0]    salt;
    logic [63:0]    iv;
    logic [31:0]    block_ctr;
    t_cipher_word   pending_words[$];

    initial begin
        o_mismatch_count = 0;
        o_pending_count  = 0;
    end

    function automatic logic [31:0] rotl(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic t_cc_words quarter_mix(t_cc_words s, int a, int b, int c, int d);
        s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 7);
        return s;
    endfunction

    function automatic t_cc_words keystream(logic [31:0] ctr);
        t_cc_words start;
        t_cc_words w;
        start[0] = EXPAND_0;
        start[1] = EXPAND_1;
        start[2] = EXPAND_2;
        start[3] = EXPAND_3;
        for (int i = 0; i < 8; i++) begin
            start[4 + i] = key[32*i +: 32];
        end
        start[12] = ctr;
        start[13] = salt;
        start[14] = iv[31:0];
        start[15] = iv[63:32];
        w = start;
        for (int r = 0; r < DOUBLE_ROUND_COUNT; r++) begin
            w = quarter_mix(w, 0, 4, 8, 12);
            w = quarter_mix(w, 1, 5, 9, 13);
            w = quarter_mix(w, 2, 6, 10, 14);
            w = quarter_mix(w, 3, 7, 11, 15);
            w = quarter_mix(w, 0, 5, 10, 15);
            w = quarter_mix(w, 1, 6, 11, 12);
            w = quarter_mix(w, 2, 7, 8, 13);
            w = quarter_mix(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) begin
            w[i] = w[i] + start[i];
        end
        return w;
    endfunction

    function automatic t_cipher_word xor_keystream(t_block data, logic [6:0] count,
                                                   logic last);
        t_cipher_word result;
        t_cc_words    ks;
        logic [6:0]   valid_bytes;
        logic [63:0]  lane;
        ks = keystream(block_ctr);
        valid_bytes = (count > FULL_BLOCK) ? FULL_BLOCK : count;
        for (int i = 0; i < 8; i++) begin
            lane = data[i] ^ {ks[2*i + 1], ks[2*i]};
            for (int j = 0; j < 8; j++) begin
                if (8*i + j >= int'(valid_bytes)) begin
                    lane[8*j +: 8] = 8'h00;
                end
            end
            result.lanes[i] = lane;
        end
        result.count = count;
        result.last  = last;
        return result;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        o_mismatch_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_cipher_word want;
        if (!i_rst_n) begin
            key       = '0;
            salt      = '0;
            iv        = '0;
            block_ctr = 32'd1;
            pending_words.delete();
            o_pending_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_KEY_LOW:      key[63:0]    = i_cfg_data;
                    REG_KEY_MID_LOW:  key[127:64]  = i_cfg_data;
                    REG_KEY_MID_HIGH: key[191:128] = i_cfg_data;
                    REG_KEY_HIGH:     key[255:192] = i_cfg_data;
                    REG_SALT_WORD:    salt         = i_cfg_data[31:0];
                    REG_IV_WORD:      iv           = i_cfg_data;
                    default:          ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_words.size() == 0) begin
                    report("output word with nothing pending, lane 0", i_out_data[0], '0);
                end else begin
                    want = pending_words.pop_front();
                    for (int i = 0; i < 8; i++) begin
                        if (i_out_data[i] !== want.lanes[i]) begin
                            report($sformatf("out_%0d", i), i_out_data[i], want.lanes[i]);
                        end
                    end
                    if (i_out_count !== want.count) begin
                        report("out_byte_count", 64'(i_out_count), 64'(want.count));
                    end
                    if (i_out_last !== want.last) begin
                        report("out_last", 64'(i_out_last), 64'(want.last));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_words.push_back(xor_keystream(i_in_data, i_in_count, i_in_last));
                block_ctr = i_in_last ? 32'd1 : block_ctr + 32'd1;
            end
            o_pending_count = pending_words.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the chacha20_stream_xor testbench: clock, reset, key and block stimulus.
// Depends on cc20_pkg, the block under test and cc20_xor_checker, which compares every output word.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cc20_pkg::*;

    localparam int         DRC         = 10;
    localparam int         ITEM_TARGET = 1950;
    localparam int         STEADY_PHASE = 3;
    localparam t_cfg_idx   REG_SPARE_A = 3'd6;
    localparam t_cfg_idx   REG_SPARE_B = 3'd7;
    localparam logic [6:0] FULL_BLOCK  = 7'd64;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    t_block      in_lanes;
    logic [6:0]  i_byte_count;
    logic        i_last_block;
    logic        o_out_valid;
    logic        i_out_ready;
    wire  [63:0] out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7;
    wire  [6:0]  o_out_byte_count;
    wire         o_out_last;
    int          mismatch_count;
    int          pending_count;
    int          sent;
    bit          steady;

    always #5 i_clk = ~i_clk;

    chacha20_stream_xor #(
        .DOUBLE_ROUND_COUNT(DRC)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_0         (in_lanes[0]),
        .i_data_1         (in_lanes[1]),
        .i_data_2         (in_lanes[2]),
        .i_data_3         (in_lanes[3]),
        .i_data_4         (in_lanes[4]),
        .i_data_5         (in_lanes[5]),
        .i_data_6         (in_lanes[6]),
        .i_data_7         (in_lanes[7]),
        .i_byte_count     (i_byte_count),
        .i_last_block     (i_last_block),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_0          (out_0),
        .o_out_1          (out_1),
        .o_out_2          (out_2),
        .o_out_3          (out_3),
        .o_out_4          (out_4),
        .o_out_5          (out_5),
        .o_out_6          (out_6),
        .o_out_7          (out_7),
        .o_out_byte_count (o_out_byte_count),
        .o_out_last       (o_out_last)
    );

    cc20_xor_checker #(
        .DOUBLE_ROUND_COUNT(DRC)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_in_data        (in_lanes),
        .i_in_count       (i_byte_count),
        .i_in_last        (i_last_block),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_out_data       ({out_7, out_6, out_5, out_4, out_3, out_2, out_1, out_0}),
        .i_out_count      (o_out_byte_count),
        .i_out_last       (o_out_last),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    always @(negedge i_clk) begin
        i_out_ready = steady || ($urandom_range(0, 99) >= 10);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_block rand_block();
        t_block b;
        for (int i = 0; i < 8; i++) begin
            b[i] = rand64();
        end
        return b;
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    task automatic send_block(input t_block data, input logic [6:0] count, input logic last);
        @(negedge i_clk);
        if (!steady && $urandom_range(0, 99) < 10) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_lanes     = data;
        i_byte_count = count;
        i_last_block = last;
        i_in_valid   = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [63:0] value);
        write_reg(REG_KEY_LOW, value);
        write_reg(REG_KEY_MID_LOW, value);
        write_reg(REG_KEY_MID_HIGH, value);
        write_reg(REG_KEY_HIGH, value);
        write_reg(REG_SALT_WORD, value);
        write_reg(REG_IV_WORD, value);
    endtask

    // Mostly well-formed messages: full blocks then a last block of any length,
    // with some zero, oversized and short counts and early last flags mixed in.
    task automatic run_message(input int len);
        t_block     data;
        logic [6:0] count;
        logic       last;
        for (int b = 0; b < len; b++) begin
            last  = (b == len - 1);
            count = last ? ($urandom_range(0, 1) ? FULL_BLOCK : 7'($urandom_range(1, 64)))
                         : FULL_BLOCK;
            if ($urandom_range(0, 99) < 10) begin
                case ($urandom_range(0, 3))
                    0:       count = '0;
                    1:       count = 7'($urandom_range(65, 127));
                    2:       count = 7'($urandom_range(1, 63));
                    default: last = 1'b1;
                endcase
            end
            case ($urandom_range(0, 19))
                0:       data = '0;
                1:       data = '1;
                default: data = rand_block();
            endcase
            send_block(data, count, last);
        end
    endtask

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int phase;
        int phase_items;
        int phase_start;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_KEY_LOW;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        in_lanes     = '0;
        i_byte_count = FULL_BLOCK;
        i_last_block = 1'b0;
        i_out_ready  = 1'b1;
        steady       = 1'b0;
        sent         = 0;
        phase        = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset configuration: all-zero key, salt and iv.
        send_block('0, FULL_BLOCK, 1'b0);
        send_block('1, FULL_BLOCK, 1'b0);
        send_block(rand_block(), FULL_BLOCK, 1'b1);
        send_block(rand_block(), 7'd1, 1'b1);
        send_block(rand_block(), 7'd0, 1'b0);
        send_block(rand_block(), 7'd0, 1'b1);
        send_block(rand_block(), 7'd127, 1'b0);
        send_block(rand_block(), 7'd65, 1'b1);
        send_block(rand_block(), 7'd63, 1'b0);
        send_block(rand_block(), FULL_BLOCK, 1'b0);
        send_block(rand_block(), 7'd8, 1'b1);

        drain();
        write_all('1);
        write_reg(REG_SPARE_A, rand64());
        write_reg(REG_SPARE_B, rand64());
        send_block('1, FULL_BLOCK, 1'b0);
        send_block('0, FULL_BLOCK, 1'b0);
        send_block(rand_block(), 7'd57, 1'b1);

        drain();
        write_all('0);
        send_block(rand_block(), 7'd9, 1'b0);
        send_block(rand_block(), 7'd56, 1'b1);

        drain();
        write_reg(REG_KEY_LOW, rand64());
        write_reg(REG_KEY_MID_LOW, rand64());
        write_reg(REG_KEY_MID_HIGH, rand64());
        write_reg(REG_KEY_HIGH, rand64());
        write_reg(REG_SALT_WORD, rand64());
        write_reg(REG_IV_WORD, rand64());
        send_block(rand_block(), FULL_BLOCK, 1'b0);
        send_block(rand_block(), 7'd33, 1'b1);

        while (sent < ITEM_TARGET) begin
            drain();
            steady = (phase == STEADY_PHASE);
            if (phase % 4 == 0) begin
                write_reg(REG_KEY_LOW, pick_value());
                write_reg(REG_KEY_MID_LOW, pick_value());
                write_reg(REG_KEY_MID_HIGH, pick_value());
                write_reg(REG_KEY_HIGH, pick_value());
                write_reg(REG_SALT_WORD, pick_value());
                write_reg(REG_IV_WORD, pick_value());
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    write_reg(t_cfg_idx'($urandom_range(0, 7)), pick_value());
                end
            end
            phase_items = $urandom_range(60, 140);
            phase_start = sent;
            while (sent - phase_start < phase_items) run_message($urandom_range(1, 12));
            phase++;
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        steady     = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (2 * DRC + 10) @(negedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
